// ===== design/miu_pkg.sv =====
// Package with opcodes, function codes, exception codes and shared types of the execute unit.
package miu_pkg;

  // Primary opcodes.
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;

  // Coprocessor, load and store opcodes, which the unit does not handle.
  localparam logic [5:0] OP_COP0    = 6'h10;
  localparam logic [5:0] OP_COP1    = 6'h11;
  localparam logic [5:0] OP_COP2    = 6'h12;
  localparam logic [5:0] OP_COP3    = 6'h13;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LWL     = 6'h22;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_LWR     = 6'h26;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SWL     = 6'h2A;
  localparam logic [5:0] OP_SW      = 6'h2B;
  localparam logic [5:0] OP_SWR     = 6'h2E;
  localparam logic [5:0] OP_LWC0    = 6'h30;
  localparam logic [5:0] OP_LWC1    = 6'h31;
  localparam logic [5:0] OP_LWC2    = 6'h32;
  localparam logic [5:0] OP_LWC3    = 6'h33;
  localparam logic [5:0] OP_SWC0    = 6'h38;
  localparam logic [5:0] OP_SWC1    = 6'h39;
  localparam logic [5:0] OP_SWC2    = 6'h3A;
  localparam logic [5:0] OP_SWC3    = 6'h3B;

  // Function codes of the special opcode.
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_BREAK   = 6'h0D;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_DIVU    = 6'h1B;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;
  localparam logic [5:0] FN_SLTU    = 6'h2B;

  localparam logic [4:0]  LINK_REG  = 5'd31;
  localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
  localparam int          DivSteps  = 32;

  // Exception codes.
  typedef enum logic [2:0] {
    EXC_NONE     = 3'd0,
    EXC_OVERFLOW = 3'd1,
    EXC_SYSCALL  = 3'd2,
    EXC_BREAK    = 3'd3,
    EXC_RESERVED = 3'd4,
    EXC_MEMCOP   = 3'd5
  } exc_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV,
    ST_DIV_FIX,
    ST_OUT
  } state_e;

  // Kind of the long operation found at decode.
  typedef enum logic [1:0] {
    LONG_NONE,
    LONG_MUL,
    LONG_DIV
  } long_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;      // capture the input word and run the part that needs no long unit
    logic mul_lo;    // first partial product step
    logic mul_hi;    // second partial product step
    logic div_step;  // one restoring divide step
    logic div_fix;   // signs and special cases of the divide
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    long_e kind;
    logic  div_last;
  } stat_t;

  // Result word.
  typedef struct packed {
    logic [2:0]  exception_code;
    logic [31:0] branch_target;
    logic        jump_taken;
    logic        is_control_transfer;
    logic [31:0] lo_value;
    logic [31:0] hi_value;
    logic [31:0] dest_value;
    logic [4:0]  dest_index;
    logic        dest_write;
  } result_t;

endpackage

// ===== design/miu_ctrl.sv =====
// Controller state machine of the execute unit.
module miu_ctrl
  import miu_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_fire_i,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_OUT;
        end
      end
      ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_OUT;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_DIV_FIX;
        end
      end
      ST_DIV_FIX: begin
        cmd_o.div_fix = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        // A word just loaded may still need the long unit.
        if (stat_i.kind == LONG_MUL) begin
          state_d = ST_MUL_LO;
        end else if (stat_i.kind == LONG_DIV) begin
          state_d = ST_DIV;
        end else begin
          out_valid_o = 1'b1;
          in_ready_o  = out_ready_i;
          if (out_ready_i) begin
            state_d = ST_IDLE;
            if (in_fire_i) begin
              cmd_o.load = 1'b1;
              state_d    = ST_OUT;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== design/miu_datapath.sv =====
// Datapath of the execute unit: decode, ALU, multiplier steps, divider and HI/LO.
module miu_datapath
  import miu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [31:0] instruction_word_i,
  input  logic [31:0] source_a_value_i,
  input  logic [31:0] source_b_value_i,
  input  logic [31:0] delay_slot_pc_i,
  output stat_t       stat_o,
  output result_t     result_o
);

  logic [31:0] hi_q, lo_q;
  result_t     res_q, res_d;
  long_e       kind_q, kind_d;
  logic        signed_q, signed_d;
  logic [31:0] a_q, b_q;
  logic [31:0] opa_q, opb_q;
  logic [31:0] rem_q;
  logic [31:0] quo_q;
  logic [5:0]  cnt_q;
  logic [63:0] plo_q;
  logic [63:0] prod_full;
  logic [32:0] rem_shift, rem_sub;
  logic [31:0] q_fix, r_fix, div_hi, div_lo;

  // Decode fields.
  logic [5:0]  op, fn;
  logic [4:0]  rt, rd, sa;
  logic [31:0] a, b, pc, imm_se, imm_ze, btarget, link, sum, diff, addi;
  logic        lt_s, lt_u, lti_s, lti_u, a_neg;

  assign op     = instruction_word_i[31:26];
  assign rt     = instruction_word_i[20:16];
  assign rd     = instruction_word_i[15:11];
  assign sa     = instruction_word_i[10:6];
  assign fn     = instruction_word_i[5:0];
  assign a      = source_a_value_i;
  assign b      = source_b_value_i;
  assign pc     = delay_slot_pc_i;
  assign imm_ze = {16'd0, instruction_word_i[15:0]};
  assign imm_se = {{16{instruction_word_i[15]}}, instruction_word_i[15:0]};
  assign btarget = pc + {imm_se[29:0], 2'b00};
  assign link   = pc + 32'd4;
  assign sum    = a + b;
  assign diff   = a - b;
  assign addi   = a + imm_se;
  assign lt_s   = $signed(a) < $signed(b);
  assign lt_u   = a < b;
  assign lti_s  = $signed(a) < $signed(imm_se);
  assign lti_u  = a < imm_se;
  assign a_neg  = a[31];

  // Execution of the input word without the long unit; registered on load.
  always_comb begin
    logic        wr, ctl, tk;
    logic [4:0]  widx;
    logic [31:0] wval, tgt, nhi, nlo;
    exc_e        exc;
    wr = 1'b0; ctl = 1'b0; tk = 1'b0; widx = '0; wval = '0; tgt = '0;
    nhi = hi_q; nlo = lo_q; exc = EXC_NONE;
    kind_d = LONG_NONE; signed_d = 1'b0;
    case (op)
      OP_SPECIAL: begin
        case (fn)
          FN_SLL:  begin wr = 1'b1; widx = rd; wval = b << sa; end
          FN_SRL:  begin wr = 1'b1; widx = rd; wval = b >> sa; end
          FN_SRA:  begin wr = 1'b1; widx = rd; wval = $unsigned($signed(b) >>> sa); end
          FN_SLLV: begin wr = 1'b1; widx = rd; wval = b << a[4:0]; end
          FN_SRLV: begin wr = 1'b1; widx = rd; wval = b >> a[4:0]; end
          FN_SRAV: begin
            wr = 1'b1; widx = rd; wval = $unsigned($signed(b) >>> a[4:0]);
          end
          FN_JR:   begin ctl = 1'b1; tk = 1'b1; tgt = a; end
          FN_JALR: begin
            ctl = 1'b1; tk = 1'b1; tgt = a; wr = 1'b1; widx = rd; wval = link;
          end
          FN_SYSCALL: exc = EXC_SYSCALL;
          FN_BREAK:   exc = EXC_BREAK;
          FN_MFHI: begin wr = 1'b1; widx = rd; wval = hi_q; end
          FN_MTHI: nhi = a;
          FN_MFLO: begin wr = 1'b1; widx = rd; wval = lo_q; end
          FN_MTLO: nlo = a;
          FN_MULT:  begin kind_d = LONG_MUL; signed_d = 1'b1; end
          FN_MULTU: kind_d = LONG_MUL;
          FN_DIV:   begin kind_d = LONG_DIV; signed_d = 1'b1; end
          FN_DIVU:  kind_d = LONG_DIV;
          FN_ADD: begin
            if (!(a[31] ^ b[31]) && (sum[31] ^ a[31])) exc = EXC_OVERFLOW;
            else begin wr = 1'b1; widx = rd; wval = sum; end
          end
          FN_ADDU: begin wr = 1'b1; widx = rd; wval = sum; end
          FN_SUB: begin
            if ((a[31] ^ b[31]) && (diff[31] ^ a[31])) exc = EXC_OVERFLOW;
            else begin wr = 1'b1; widx = rd; wval = diff; end
          end
          FN_SUBU: begin wr = 1'b1; widx = rd; wval = diff; end
          FN_AND:  begin wr = 1'b1; widx = rd; wval = a & b; end
          FN_OR:   begin wr = 1'b1; widx = rd; wval = a | b; end
          FN_XOR:  begin wr = 1'b1; widx = rd; wval = a ^ b; end
          FN_NOR:  begin wr = 1'b1; widx = rd; wval = ~(a | b); end
          FN_SLT:  begin wr = 1'b1; widx = rd; wval = {31'd0, lt_s}; end
          FN_SLTU: begin wr = 1'b1; widx = rd; wval = {31'd0, lt_u}; end
          default: exc = EXC_RESERVED;
        endcase
      end
      OP_REGIMM: begin
        ctl = 1'b1;
        if (rt[4:1] == 4'b1000) begin wr = 1'b1; widx = LINK_REG; wval = link; end
        if (a_neg ^ rt[0]) begin tk = 1'b1; tgt = btarget; end
      end
      OP_J, OP_JAL: begin
        ctl = 1'b1; tk = 1'b1;
        tgt = {link[31:28], instruction_word_i[25:0], 2'b00};
        if (op == OP_JAL) begin wr = 1'b1; widx = LINK_REG; wval = link; end
      end
      OP_BEQ:  begin ctl = 1'b1; if (a == b) begin tk = 1'b1; tgt = btarget; end end
      OP_BNE:  begin ctl = 1'b1; if (a != b) begin tk = 1'b1; tgt = btarget; end end
      OP_BLEZ: begin
        ctl = 1'b1; if (a_neg || a == '0) begin tk = 1'b1; tgt = btarget; end
      end
      OP_BGTZ: begin
        ctl = 1'b1; if (!a_neg && a != '0) begin tk = 1'b1; tgt = btarget; end
      end
      OP_ADDI: begin
        if (!(a[31] ^ imm_se[31]) && (addi[31] ^ a[31])) exc = EXC_OVERFLOW;
        else begin wr = 1'b1; widx = rt; wval = addi; end
      end
      OP_ADDIU: begin wr = 1'b1; widx = rt; wval = addi; end
      OP_SLTI:  begin wr = 1'b1; widx = rt; wval = {31'd0, lti_s}; end
      OP_SLTIU: begin wr = 1'b1; widx = rt; wval = {31'd0, lti_u}; end
      OP_ANDI:  begin wr = 1'b1; widx = rt; wval = a & imm_ze; end
      OP_ORI:   begin wr = 1'b1; widx = rt; wval = a | imm_ze; end
      OP_XORI:  begin wr = 1'b1; widx = rt; wval = a ^ imm_ze; end
      OP_LUI:   begin wr = 1'b1; widx = rt; wval = {instruction_word_i[15:0], 16'd0}; end
      OP_COP0, OP_COP1, OP_COP2, OP_COP3, OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU,
      OP_LWR, OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR, OP_LWC0, OP_LWC1, OP_LWC2, OP_LWC3,
      OP_SWC0, OP_SWC1, OP_SWC2, OP_SWC3: exc = EXC_MEMCOP;
      default: exc = EXC_RESERVED;
    endcase
    if (exc != EXC_NONE) begin
      wr = 1'b0; ctl = 1'b0; tk = 1'b0; nhi = hi_q; nlo = lo_q;
    end
    if (!wr || widx == '0) begin
      wr = 1'b0; widx = '0; wval = '0;
    end
    if (!tk) tgt = '0;
    res_d.dest_write          = wr;
    res_d.dest_index          = widx;
    res_d.dest_value          = wval;
    res_d.hi_value            = nhi;
    res_d.lo_value            = nlo;
    res_d.is_control_transfer = ctl;
    res_d.jump_taken          = tk;
    res_d.branch_target       = tgt;
    res_d.exception_code      = exc;
  end

  // Multiplier: magnitudes 32x16 per step, sign fixed at the end.
  logic [47:0] pp_lo, pp_hi;
  logic        prod_neg;
  assign pp_lo     = opa_q * {16'd0, opb_q[15:0]};
  assign pp_hi     = opa_q * {16'd0, opb_q[31:16]};
  assign prod_neg  = signed_q & (a_q[31] ^ b_q[31]);
  assign prod_full = plo_q + {pp_hi, 16'd0};

  // Restoring divide step on magnitudes.
  assign rem_shift = {rem_q, quo_q[31]};
  assign rem_sub   = rem_shift - {1'b0, opb_q};

  // Sign fixup and special cases of the divide.
  always_comb begin
    q_fix = (signed_q && (a_q[31] ^ b_q[31])) ? (32'd0 - quo_q) : quo_q;
    r_fix = (signed_q && a_q[31]) ? (32'd0 - rem_q) : rem_q;
    div_hi = r_fix;
    div_lo = q_fix;
    if (b_q == '0) begin
      div_hi = a_q;
      div_lo = (signed_q && a_q[31]) ? 32'd1 : ALL_ONES;
    end else if (signed_q && a_q == SIGN_BIT && b_q == ALL_ONES) begin
      div_hi = '0;
      div_lo = SIGN_BIT;
    end
  end

  // Payload and long-operation registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_q    <= res_d;
      a_q      <= a;
      b_q      <= b;
      signed_q <= signed_d;
      opa_q    <= (signed_d && a[31]) ? (32'd0 - a) : a;
      opb_q    <= (signed_d && b[31]) ? (32'd0 - b) : b;
      rem_q    <= '0;
      quo_q    <= (signed_d && a[31]) ? (32'd0 - a) : a;
    end
    if (cmd_i.mul_lo) begin
      plo_q <= {16'd0, pp_lo};
    end
    if (cmd_i.div_step) begin
      // With a nonzero divisor the kept remainder stays below the divisor and fits in 32 bits.
      if (!rem_sub[32]) begin
        rem_q <= rem_sub[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_shift[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
    if (cmd_i.mul_hi) begin
      res_q.hi_value <= prod_neg ? ~prod_full[63:32] + {31'd0, prod_full[31:0] == '0}
                                 : prod_full[63:32];
      res_q.lo_value <= prod_neg ? 32'd0 - prod_full[31:0] : prod_full[31:0];
    end
    if (cmd_i.div_fix) begin
      res_q.hi_value <= div_hi;
      res_q.lo_value <= div_lo;
    end
  end

  // Control registers: long kind, step count, HI and LO.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= LONG_NONE;
      cnt_q  <= '0;
      hi_q   <= '0;
      lo_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        kind_q <= kind_d;
        cnt_q  <= '0;
        hi_q   <= res_d.hi_value;
        lo_q   <= res_d.lo_value;
      end else begin
        if (kind_q != LONG_NONE) kind_q <= LONG_NONE;
        if (cmd_i.div_step) cnt_q <= cnt_q + 6'd1;
        if (cmd_i.mul_hi) begin
          hi_q <= prod_neg ? ~prod_full[63:32] + {31'd0, prod_full[31:0] == '0}
                           : prod_full[63:32];
          lo_q <= prod_neg ? 32'd0 - prod_full[31:0] : prod_full[31:0];
        end
        if (cmd_i.div_fix) begin
          hi_q <= div_hi;
          lo_q <= div_lo;
        end
      end
    end
  end

  assign stat_o.kind     = kind_q;
  assign stat_o.div_last = (cnt_q == 6'(DivSteps - 1));
  assign result_o        = res_q;

endmodule

// ===== design/mips_integer_execute_unit.sv =====
// Top level of the MIPS I integer execute unit.
//
// Channel  Direction  Payload
// s_axis   in         tdata: instruction_word, source_a_value, source_b_value, delay_slot_pc
// m_axis   out        tdata: dest_write .. exception_code (see port comment)
//
// A short instruction's result is registered on accept and offered from ST_OUT.
// mult/multu go through two 32x16 partial product steps, ST_MUL_LO and ST_MUL_HI.
// div/divu run one restoring step per quotient bit, then a sign and special-case fixup.
// HI and LO reset to zero. One word is in flight at a time; the next is
// taken in the cycle its predecessor's result is taken.
module mips_integer_execute_unit
  import miu_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] instruction_word, [63:32] source_a_value, [95:64] source_b_value,
  // [127:96] delay_slot_pc
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] dest_write, [5:1] dest_index, [37:6] dest_value, [69:38] hi_value,
  // [101:70] lo_value, [102] is_control_transfer, [103] jump_taken,
  // [135:104] branch_target, [138:136] exception_code, [143:139] zero
  output logic [143:0] m_axis_tdata
);

  cmd_t    cmd;
  stat_t   stat;
  result_t res;
  logic    in_fire;

  assign in_fire = s_axis_tvalid & s_axis_tready;

  miu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  miu_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .instruction_word_i (s_axis_tdata[31:0]),
    .source_a_value_i   (s_axis_tdata[63:32]),
    .source_b_value_i   (s_axis_tdata[95:64]),
    .delay_slot_pc_i    (s_axis_tdata[127:96]),
    .stat_o             (stat),
    .result_o           (res)
  );

  assign m_axis_tdata = {5'd0, res};

`ifndef SYNTHESIS
  // A result is never offered while a word is being taken without it leaving.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tready && m_axis_tvalid) |-> m_axis_tready)
    else $error("input accepted while result stalled");

  // An exception never comes with a register write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[138:136] != EXC_NONE) |-> !m_axis_tdata[0])
    else $error("write with exception");

  // Register zero is never written.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[5:1] != 5'd0))
    else $error("write to register zero");

  // Commands are mutually exclusive.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(cmd))
    else $error("overlapping datapath commands");
`endif

endmodule
